>>> rtl/stks_pkg.sv
package stks_pkg;

  localparam int SCORE_W = 16;
  localparam int POS_W   = 10;
  localparam int RANK_W  = 3;
  localparam int K_W     = 3;

  localparam logic [K_W-1:0] K_RESET = 3'd5;

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [K_W-1:0]     k_t;

  typedef struct packed {
    score_t score;
    logic   frame_end;
  } item_t;

  // Both zeros map to the same key, so they compare equal.
  function automatic score_t score_key(input score_t bits);
    score_t mag;
    mag = {1'b0, bits[SCORE_W-2:0]};
    if (bits[SCORE_W-1]) begin
      return 16'h8000 - mag;
    end
    return 16'h8000 + mag;
  endfunction

  function automatic logic is_nan(input score_t bits);
    return (bits[14:10] == 5'h1f) && (bits[9:0] != 10'h000);
  endfunction

endpackage

>>> rtl/stks_list.sv
module stks_list #(
  parameter int TOP_K     = 5,
  parameter int MAX_COUNT = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  stks_pkg::item_t                item,
  output stks_pkg::score_t               snap_score [TOP_K],
  output stks_pkg::pos_t                 snap_pos [TOP_K],
  output logic [$clog2(TOP_K+1)-1:0]     snap_filled,
  output logic                           snap_ovf
);

  localparam int CNT_W  = $clog2(TOP_K + 1);
  localparam int ITEM_W = $clog2(MAX_COUNT + 1);

  stks_pkg::score_t    best_score [TOP_K];
  stks_pkg::pos_t      best_pos [TOP_K];
  logic [CNT_W-1:0]    filled;
  logic [ITEM_W-1:0]   item_counter;
  logic                overflow_seen;

  logic [ITEM_W-1:0]   item_counter_next;
  logic                at_limit;
  logic                do_insert;
  logic                hit;
  logic                add_new;
  stks_pkg::score_t    key;
  stks_pkg::pos_t      pos;
  logic [TOP_K-1:0]    eq;
  logic [TOP_K-1:0]    gt;

  always_comb begin
    at_limit  = (item_counter == ITEM_W'(MAX_COUNT));
    do_insert = !at_limit && !stks_pkg::is_nan(item.score);
    key       = stks_pkg::score_key(item.score);
    pos       = stks_pkg::POS_W'(item_counter);
    for (int i = 0; i < TOP_K; i++) begin
      eq[i] = (CNT_W'(i) < filled) && (stks_pkg::score_key(best_score[i]) == key);
      gt[i] = (CNT_W'(i) < filled) && (stks_pkg::score_key(best_score[i]) > key);
    end
    hit     = |eq;
    add_new = do_insert && !hit && !gt[TOP_K-1];
    snap_filled = (add_new && (filled < CNT_W'(TOP_K))) ? filled + CNT_W'(1) : filled;
    snap_ovf    = overflow_seen | at_limit;
    item_counter_next = at_limit ? item_counter : item_counter + ITEM_W'(1);
  end

  // The stored list is sorted, so the entries above the new score form a prefix.
  for (genvar j = 0; j < TOP_K; j++) begin : g_entry
    logic is_slot;
    if (j == 0) begin : g_first
      assign is_slot = !gt[0];
    end else begin : g_rest
      assign is_slot = !gt[j] && gt[j-1];
    end

    always_comb begin
      snap_score[j] = best_score[j];
      snap_pos[j]   = best_pos[j];
      if (do_insert && hit) begin
        if (eq[j]) begin
          snap_pos[j] = pos;
        end
      end else if (add_new && !gt[j]) begin
        if (is_slot) begin
          snap_score[j] = item.score;
          snap_pos[j]   = pos;
        end else begin
          snap_score[j] = best_score[(j > 0) ? j - 1 : 0];
          snap_pos[j]   = best_pos[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled        <= '0;
      item_counter  <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      if (item.frame_end) begin
        filled        <= '0;
        item_counter  <= '0;
        overflow_seen <= 1'b0;
      end else begin
        filled        <= snap_filled;
        item_counter  <= item_counter_next;
        overflow_seen <= snap_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !item.frame_end) begin
      best_score <= snap_score;
      best_pos   <= snap_pos;
    end
  end

endmodule

>>> rtl/streaming_top_k_selector.sv
// Streaming top-k selector for half-precision scores.
// Scores enter on the input channel (in_valid, in_stall, score_bits, frame_end),
// one transfer per cycle while in_stall is low. An input register holds each
// item, then its score is compared against all stored entries at once and the
// sorted list is updated; the block sustains one score per cycle when not stalled.
// On the item with frame_end set, the updated list is copied into an output
// buffer and the list is cleared for the next frame. The buffer then presents
// min(k, entries held) results, k being k_in_use clamped to 1..TOP_K, on the
// output channel (out_valid, out_stall), one per cycle while out_stall is low,
// largest first; run_end marks the last one. The first result is presented once
// the frame_end item has left the input register and the buffer has been loaded.
// A frame_end item waits in the input register while the previous frame is
// still draining, and in_stall is raised until the last result is taken.
// Other scores keep flowing while results drain.
// k_in_use is written through cfg_write and cfg_data; the user must do so only
// while the block is idle, which the block itself does not enforce. Reset clears
// the list, the position counter and the output buffer, and sets k_in_use to 5.
module streaming_top_k_selector #(
  parameter int TOP_K     = 5,
  parameter int MAX_COUNT = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  stks_pkg::k_t            cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  stks_pkg::score_t        score_bits,
  input  logic                    frame_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output stks_pkg::rank_t         rank,
  output stks_pkg::pos_t          position,
  output stks_pkg::score_t        top_score_bits,
  output logic                    run_end,
  output logic                    overflowed
);

  localparam int CNT_W = $clog2(TOP_K + 1);

  stks_pkg::k_t      k_in_use;
  logic              s0_valid;
  stks_pkg::item_t   s0_item;
  logic              s0_go;
  logic              step;
  logic              out_xfer;

  stks_pkg::score_t  snap_score [TOP_K];
  stks_pkg::pos_t    snap_pos [TOP_K];
  logic [CNT_W-1:0]  snap_filled;
  logic              snap_ovf;
  logic [CNT_W-1:0]  k_eff;
  logic [CNT_W-1:0]  emit_count;

  stks_pkg::score_t  dump_score [TOP_K];
  stks_pkg::pos_t    dump_pos [TOP_K];
  logic [CNT_W-1:0]  dump_left;
  stks_pkg::rank_t   dump_rank;
  logic              dump_ovf;

  stks_list #(
    .TOP_K     (TOP_K),
    .MAX_COUNT (MAX_COUNT)
  ) u_list (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (s0_item),
    .snap_score  (snap_score),
    .snap_pos    (snap_pos),
    .snap_filled (snap_filled),
    .snap_ovf    (snap_ovf)
  );

  always_comb begin
    out_xfer = out_valid && !out_stall;
    s0_go    = !(s0_item.frame_end && (dump_left != '0) &&
                 !((dump_left == CNT_W'(1)) && out_xfer));
    step     = s0_valid && s0_go;
    in_stall = s0_valid && !s0_go;

    if (k_in_use == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(k_in_use) > TOP_K) begin
      k_eff = CNT_W'(TOP_K);
    end else begin
      k_eff = CNT_W'(k_in_use);
    end
    emit_count = (snap_filled < k_eff) ? snap_filled : k_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_in_use <= stks_pkg::K_RESET;
      s0_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        k_in_use <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        s0_valid <= 1'b1;
      end else if (step) begin
        s0_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s0_item <= '{score: score_bits, frame_end: frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dump_left <= '0;
      dump_rank <= stks_pkg::RANK_W'(1);
      dump_ovf  <= 1'b0;
    end else if (step && s0_item.frame_end) begin
      dump_left <= emit_count;
      dump_rank <= stks_pkg::RANK_W'(1);
      dump_ovf  <= snap_ovf;
    end else if (out_xfer) begin
      dump_left <= dump_left - CNT_W'(1);
      dump_rank <= dump_rank + stks_pkg::RANK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step && s0_item.frame_end) begin
      dump_score <= snap_score;
      dump_pos   <= snap_pos;
    end else if (out_xfer) begin
      for (int j = 0; j < TOP_K - 1; j++) begin
        dump_score[j] <= dump_score[j+1];
        dump_pos[j]   <= dump_pos[j+1];
      end
    end
  end

  assign out_valid      = (dump_left != '0);
  assign rank           = dump_rank;
  assign position       = dump_pos[0];
  assign top_score_bits = dump_score[0];
  assign run_end        = (dump_left == CNT_W'(1));
  assign overflowed     = dump_ovf;

endmodule

>>> test/ranking_monitor.sv
module ranking_monitor #(
  parameter int DEPTH     = 5,
  parameter int MAX_COUNT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  stks_pkg::k_t     cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  stks_pkg::score_t score_bits,
  input  logic             frame_end,
  input  logic             out_valid,
  input  logic             out_stall,
  input  stks_pkg::rank_t  rank,
  input  stks_pkg::pos_t   position,
  input  stks_pkg::score_t top_score_bits,
  input  logic             run_end,
  input  logic             overflowed,
  output int               fail_count,
  output int               pending,
  output int               ranks_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    stks_pkg::rank_t  rank;
    stks_pkg::pos_t   pos;
    stks_pkg::score_t score;
    logic             last;
    logic             ovf;
  } ranked_t;

  stks_pkg::score_t kept_score [DEPTH];
  stks_pkg::pos_t   kept_pos [DEPTH];
  int               kept_n = 0;
  int               frame_pos = 0;
  logic             over_seen = 1'b0;
  stks_pkg::k_t     k_now = stks_pkg::K_RESET;
  ranked_t          due_ranks [$];
  int               errors = 0;
  int               checked = 0;

  // Negative scores count down from the midpoint, so both zeros land on it.
  function automatic int order_key(input stks_pkg::score_t b);
    if (b[15]) begin
      return 32768 - int'(b[14:0]);
    end
    return 32768 + int'(b[14:0]);
  endfunction

  function automatic logic is_nan_half(input stks_pkg::score_t b);
    return (&b[14:10]) && (|b[9:0]);
  endfunction

  task automatic clear_list();
    for (int i = 0; i < DEPTH; i++) begin
      kept_score[i] = '0;
      kept_pos[i] = '0;
    end
    kept_n = 0;
    frame_pos = 0;
    over_seen = 1'b0;
  endtask

  task automatic absorb_score(input stks_pkg::score_t s, input logic last);
    int      slot;
    int      kk;
    int      cnt;
    bit      hit;
    ranked_t r;
    if (frame_pos >= MAX_COUNT) begin
      over_seen = 1'b1;
    end else begin
      if (!is_nan_half(s)) begin
        slot = 0;
        hit = 1'b0;
        for (int i = 0; i < kept_n; i++) begin
          if (order_key(kept_score[i]) == order_key(s)) begin
            kept_pos[i] = stks_pkg::pos_t'(frame_pos);
            hit = 1'b1;
          end else if (order_key(kept_score[i]) > order_key(s)) begin
            slot = i + 1;
          end
        end
        if (!hit && slot < DEPTH) begin
          for (int i = (kept_n < DEPTH) ? kept_n : DEPTH - 1; i > slot; i--) begin
            kept_score[i] = kept_score[i-1];
            kept_pos[i] = kept_pos[i-1];
          end
          kept_score[slot] = s;
          kept_pos[slot] = stks_pkg::pos_t'(frame_pos);
          if (kept_n < DEPTH) begin
            kept_n++;
          end
        end
      end
      frame_pos++;
    end
    if (last) begin
      kk = (k_now == 0) ? 1 : (int'(k_now) > DEPTH) ? DEPTH : int'(k_now);
      cnt = (kept_n < kk) ? kept_n : kk;
      for (int i = 0; i < cnt; i++) begin
        r.rank = stks_pkg::rank_t'(i + 1);
        r.pos = kept_pos[i];
        r.score = kept_score[i];
        r.last = (i + 1 == cnt);
        r.ovf = over_seen;
        due_ranks.push_back(r);
      end
      clear_list();
    end
  endtask

  task automatic mismatch(input string field, input logic [15:0] want, input logic [15:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  task automatic compare_rank();
    ranked_t want;
    if (due_ranks.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got rank %0d position %0d score %h",
               $time, rank, position, top_score_bits);
    end else begin
      want = due_ranks.pop_front();
      checked++;
      if (rank !== want.rank) mismatch("rank", 16'(want.rank), 16'(rank));
      if (position !== want.pos) mismatch("position", 16'(want.pos), 16'(position));
      if (top_score_bits !== want.score) mismatch("top_score_bits", want.score, top_score_bits);
      if (run_end !== want.last) mismatch("run_end", 16'(want.last), 16'(run_end));
      if (overflowed !== want.ovf) mismatch("overflowed", 16'(want.ovf), 16'(overflowed));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      k_now = stks_pkg::K_RESET;
      clear_list();
      due_ranks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        compare_rank();
      end
      if (cfg_write) begin
        k_now = cfg_data;
      end
      if (in_valid && !in_stall) begin
        absorb_score(score_bits, frame_end);
      end
    end
    fail_count <= errors;
    pending <= due_ranks.size();
    ranks_checked <= checked;
  end

endmodule

>>> test/tb_streaming_top_k_selector.sv
module tb_streaming_top_k_selector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT       = 100000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 6;
  localparam int PHASE_ITEMS = 34;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  stks_pkg::k_t     cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  stks_pkg::score_t score_bits = '0;
  logic             frame_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  stks_pkg::rank_t  rank;
  stks_pkg::pos_t   position;
  stks_pkg::score_t top_score_bits;
  logic             run_end;
  logic             overflowed;

  int fail_count;
  int pending;
  int ranks_checked;

  bit idle_on = 1'b1;
  bit pressure_req = 1'b0;
  int scores_sent = 0;
  int frames_sent = 0;
  int cycle_count = 0;

  always #6 clk = ~clk;

  streaming_top_k_selector #(
    .TOP_K(5),
    .MAX_COUNT(1024)
  ) u_top (
    .clk, .rst, .cfg_write, .cfg_data,
    .in_valid, .in_stall, .score_bits, .frame_end,
    .out_valid, .out_stall, .rank, .position, .top_score_bits, .run_end, .overflowed
  );

  ranking_monitor #(
    .DEPTH(5),
    .MAX_COUNT(1024)
  ) u_monitor (
    .clk, .rst, .cfg_write, .cfg_data,
    .in_valid, .in_stall, .score_bits, .frame_end,
    .out_valid, .out_stall, .rank, .position, .top_score_bits, .run_end, .overflowed,
    .fail_count, .pending, .ranks_checked
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb_streaming_top_k_selector: FAIL");
      $finish;
    end
  end

  // Mix of raw patterns, a small pool that repeats values, zeros, specials and tiny values.
  function automatic stks_pkg::score_t pick_score();
    stks_pkg::score_t pool [8] = '{16'h3C00, 16'hBC00, 16'h0000, 16'h8000,
                                   16'h7C00, 16'h4500, 16'hC500, 16'h0001};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return stks_pkg::score_t'($urandom);
      5, 6: return pool[$urandom_range(0, 7)];
      7: return {1'($urandom), 15'h0000};
      8: return {1'($urandom), 5'h1f, ($urandom_range(0, 1) != 0) ? 10'h000 : 10'($urandom)};
      default: return {1'($urandom), 15'($urandom_range(0, 63))};
    endcase
  endfunction

  task automatic offer(input stks_pkg::score_t s, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    score_bits <= s;
    frame_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scores_sent++;
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      offer(pick_score(), i == len - 1);
    end
    frames_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_k(input stks_pkg::k_t v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int w;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (pressure_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = idle_on ? $urandom_range(0, 4) : 0;
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && !(pressure_req && !held)) @(posedge clk);
    end
  end

  initial begin
    stks_pkg::k_t k_steps [8] = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd4, 3'd5};
    int budget;
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Both zeros share one entry, infinities sit at the ends, NaNs are skipped and
    // scores below a full list are dropped.
    offer(16'h0000, 1'b0); offer(16'h8000, 1'b0); offer(16'h7C00, 1'b0);
    offer(16'hFC00, 1'b0); offer(16'h7E00, 1'b0); offer(16'hFFFF, 1'b0);
    offer(16'h7BFF, 1'b0); offer(16'hFBFF, 1'b0); offer(16'h0001, 1'b0);
    offer(16'h8001, 1'b0); offer(16'h7C00, 1'b0); offer(16'h3C00, 1'b1);
    // A frame of NaNs reports nothing.
    offer(16'hFE01, 1'b0); offer(16'h7C01, 1'b1);
    offer(16'h8000, 1'b1);
    // The first zero pattern stays while the position moves on.
    offer(16'h8000, 1'b0); offer(16'h0000, 1'b0); offer(16'hC000, 1'b1);
    frames_sent += 4;
    settle();

    for (int p = 0; p < 8; p++) begin
      write_k(k_steps[p]);
      idle_on = (p % 3 != 1);
      budget = PHASE_ITEMS;
      while (budget > 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
        if (len > budget) len = budget;
        send_frame(len);
        budget -= len;
      end
      settle();
    end

    // Hold the output long enough that a second frame end backs up the input.
    idle_on = 1'b0;
    pressure_req = 1'b1;
    repeat (5) send_frame(4);
    settle();

    // The last item of this frame lies past the position limit.
    for (int i = 0; i < 1025; i++) begin
      offer((i == 1023) ? 16'h7C00 : pick_score(), i == 1024);
    end
    frames_sent++;
    settle();
    idle_on = 1'b1;
    send_frame(3);
    settle();

    $display("Sent %0d scores in %0d frames and checked %0d ranked results.",
             scores_sent, frames_sent, ranks_checked);
    $display("Every k setting, signed zeros, NaNs, infinities, an overflowed frame and a long"
             , " output hold were exercised.");
    if (fail_count == 0) begin
      $display("tb_streaming_top_k_selector: PASS");
    end else begin
      $display("tb_streaming_top_k_selector: FAIL");
    end
    $finish;
  end

endmodule

>>> streaming_top_k_selector.f
rtl/stks_pkg.sv
rtl/stks_list.sv
rtl/streaming_top_k_selector.sv
test/ranking_monitor.sv
test/tb_streaming_top_k_selector.sv
